FILE: rtl/key_press_classifier_top_macros.svh
// assertion macros for the key press classifier top level
// every macro samples on clk and is disabled while rst_n is low
`ifndef KEY_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication
`define KPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/kpc_pkg.sv
// shared types and constants for the key press classifier
// no dependencies
`default_nettype none

package kpc_pkg;

  // width of the fixed key level and event mask fields
  localparam int KEY_BITS = 8;
  localparam int DB_W     = 8;
  localparam int LP_W     = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 2'd2;

  // register reset values
  localparam logic [DB_W-1:0]     DEBOUNCE_RST   = 8'd2;
  localparam logic [LP_W-1:0]     LONG_PRESS_RST = 16'd200;
  localparam logic [KEY_BITS-1:0] KEY_ENABLE_RST = 8'hFF;

  // events one key raises on one tick
  typedef struct packed {
    logic press;
    logic long_press;
    logic short_release;
    logic long_release;
  } kpc_events_t;

endpackage

`default_nettype wire

FILE: rtl/kpc_lane.sv
// one key's debounce and long-press state machine with its hold counter
// depends on kpc_pkg
`default_nettype none

module kpc_lane
  import kpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              enable,
  input  wire logic              down,
  input  wire logic [DB_W-1:0]   debounce_ticks,
  input  wire logic [LP_W-1:0]   long_press_ticks,
  output kpc_events_t            events
);

  localparam int CMP_W = (COUNT_BITS > LP_W) ? COUNT_BITS : LP_W;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HELD     = 2'd2;
  localparam logic [1:0] PH_RELEASED = 2'd3;

  logic [1:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  sat;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_W-1:0]      inc_ext, cur_ext, db_ext, lp_ext;

  // saturating increment
  assign sat       = (count_r == {COUNT_BITS{1'b1}});
  assign count_inc = sat ? count_r : count_r + 1'b1;

  // common compare width
  assign inc_ext = CMP_W'(count_inc);
  assign cur_ext = CMP_W'(count_r);
  assign db_ext  = CMP_W'(debounce_ticks);
  assign lp_ext  = CMP_W'(long_press_ticks);

  // next phase, count and events for this tick
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    events    = '0;
    if (!enable) begin
      phase_nxt = PH_IDLE;
      count_nxt = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (down) begin
            phase_nxt = PH_DEBOUNCE;
            count_nxt = '0;
          end
        end
        PH_DEBOUNCE: begin
          count_nxt = count_inc;
          if (inc_ext >= db_ext) begin
            if (down) begin
              events.press = 1'b1;
              phase_nxt    = PH_HELD;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_HELD: begin
          count_nxt = count_inc;
          if (!sat && (inc_ext == lp_ext)) begin
            events.long_press = 1'b1;
          end
          if (!down) begin
            phase_nxt = PH_RELEASED;
          end
        end
        PH_RELEASED: begin
          if (cur_ext >= lp_ext) begin
            events.long_release = 1'b1;
          end else begin
            events.short_release = 1'b1;
          end
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kpc_merge.sv
// gathers per-key events into the result masks and holds the output register
// depends on kpc_pkg
`default_nettype none

module kpc_merge
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire kpc_events_t [NUM_KEYS-1:0]  lane_ev,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [KEY_BITS-1:0]              out_press_mask,
  output logic [KEY_BITS-1:0]              out_long_press_mask,
  output logic [KEY_BITS-1:0]              out_short_release_mask,
  output logic [KEY_BITS-1:0]              out_long_release_mask
);

  logic [KEY_BITS-1:0] press_v, long_v, srel_v, lrel_v;
  logic                valid_r;
  logic [KEY_BITS-1:0] press_r, long_r, srel_r, lrel_r;

  // map lanes onto mask bits; keys without a lane read as zero
  for (genvar k = 0; k < KEY_BITS; k++) begin : g_bit
    if (k < NUM_KEYS) begin : g_lane
      assign press_v[k] = lane_ev[k].press;
      assign long_v[k]  = lane_ev[k].long_press;
      assign srel_v[k]  = lane_ev[k].short_release;
      assign lrel_v[k]  = lane_ev[k].long_release;
    end else begin : g_none
      assign press_v[k] = 1'b0;
      assign long_v[k]  = 1'b0;
      assign srel_v[k]  = 1'b0;
      assign lrel_v[k]  = 1'b0;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step) begin
      press_r <= press_v;
      long_r  <= long_v;
      srel_r  <= srel_v;
      lrel_r  <= lrel_v;
    end
  end

  assign out_valid              = valid_r;
  assign out_press_mask         = press_r;
  assign out_long_press_mask    = long_r;
  assign out_short_release_mask = srel_r;
  assign out_long_release_mask  = lrel_r;

endmodule

`default_nettype wire

FILE: rtl/key_press_classifier_top.sv
// key press classifier: debounce and long-press events for up to eight keys
// result: the event masks of a tick transaction are registered and appear in the cycle after it is accepted
// throughput: one tick per cycle while the output is not stalled; every key lane updates in parallel in that cycle
// reset: synchronous active-low rst_n puts every key idle with a zero count and
// restores debounce 2, long press 200 and all keys enabled; no clearing pass
`default_nettype none

`include "key_press_classifier_top_macros.svh"

module key_press_classifier_top
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // tick input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [KEY_BITS-1:0]  in_key_levels,
  // events
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [KEY_BITS-1:0]       out_press_mask,
  output logic [KEY_BITS-1:0]       out_long_press_mask,
  output logic [KEY_BITS-1:0]       out_short_release_mask,
  output logic [KEY_BITS-1:0]       out_long_release_mask
);

  logic [DB_W-1:0]     debounce_r;
  logic [LP_W-1:0]     long_press_r;
  logic [KEY_BITS-1:0] key_enable_r;
  logic                step;
  kpc_events_t [NUM_KEYS-1:0] lane_ev;
  logic [KEY_BITS-1:0] press_rel_clash, rel_kind_clash, press_kind_clash;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      key_enable_r <= KEY_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[DB_W-1:0];
        CFG_LONG_PRESS: long_press_r <= cfg_wdata[LP_W-1:0];
        CFG_KEY_ENABLE: key_enable_r <= cfg_wdata[KEY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // accept a tick whenever the output register is free or draining
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  // key lanes; lanes beyond the level field stay idle
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    if (k < KEY_BITS) begin : g_wired
      kpc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .enable           (key_enable_r[k]),
        .down             (in_key_levels[k]),
        .debounce_ticks   (debounce_r),
        .long_press_ticks (long_press_r),
        .events           (lane_ev[k])
      );
    end else begin : g_unwired
      kpc_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .enable           (1'b0),
        .down             (1'b0),
        .debounce_ticks   (debounce_r),
        .long_press_ticks (long_press_r),
        .events           (lane_ev[k])
      );
    end
  end

  // merge lane events into the result register
  kpc_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .step                   (step),
    .lane_ev                (lane_ev),
    .out_stall              (out_stall),
    .out_valid              (out_valid),
    .out_press_mask         (out_press_mask),
    .out_long_press_mask    (out_long_press_mask),
    .out_short_release_mask (out_short_release_mask),
    .out_long_release_mask  (out_long_release_mask)
  );

  // keys that raise events of exclusive kinds on one tick
  assign press_rel_clash  = (out_press_mask | out_long_press_mask) &
                            (out_short_release_mask | out_long_release_mask);
  assign rel_kind_clash   = out_short_release_mask & out_long_release_mask;
  assign press_kind_clash = out_press_mask & out_long_press_mask;

  // checks
  `KPC_ASSERT_NEXT(a_accept_gives_result, step, out_valid, "accepted tick left no result")
  `KPC_ASSERT_SAME(a_press_release_excl, out_valid, (press_rel_clash == 8'h00), "press and release")
  `KPC_ASSERT_SAME(a_release_kind_excl, out_valid, (rel_kind_clash == 8'h00), "both release kinds")
  `KPC_ASSERT_SAME(a_press_long_excl, out_valid, (press_kind_clash == 8'h00), "press and long press")

endmodule

`default_nettype wire

FILE: tb/key_press_classifier_top_tb.sv
// self-checking testbench for key_press_classifier_top: scan tick transactions in,
// event mask transactions out, checked against an in-bench key phase predictor
// depends on kpc_pkg and the key_press_classifier_top rtl only
`timescale 1ns / 1ps

module key_press_classifier_top_tb;
  import kpc_pkg::*;

  localparam int COUNT_BITS      = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 60;

  typedef enum logic [1:0] {
    KEY_IDLE,
    KEY_DEBOUNCE,
    KEY_HELD,
    KEY_RELEASED
  } key_phase_e;

  typedef enum int {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FREE
  } pacing_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] press;
    logic [KEY_BITS-1:0] long_press;
    logic [KEY_BITS-1:0] short_release;
    logic [KEY_BITS-1:0] long_release;
  } tick_events_t;

  // dut connections
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KEY_BITS-1:0]  in_key_levels = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KEY_BITS-1:0]  out_press_mask;
  logic [KEY_BITS-1:0]  out_long_press_mask;
  logic [KEY_BITS-1:0]  out_short_release_mask;
  logic [KEY_BITS-1:0]  out_long_release_mask;

  // predictor copy of registers and per-key state
  logic [DB_W-1:0]        db_limit;
  logic [LP_W-1:0]        lp_limit;
  logic [KEY_BITS-1:0]    key_enabled;
  key_phase_e             key_phase [KEY_BITS];
  logic [COUNT_BITS-1:0]  hold_ticks [KEY_BITS];

  // stimulus and expectation stores
  logic [KEY_BITS-1:0]    pending_levels [$];
  tick_events_t           expected_events [$];

  // per-key run generator for well-formed press sequences
  int                     run_left [KEY_BITS];
  bit                     gen_down [KEY_BITS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_requests = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;
  int idle_cycles = 0;
  int error_count = 0;

  key_press_classifier_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_key_levels          (in_key_levels),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_press_mask         (out_press_mask),
    .out_long_press_mask    (out_long_press_mask),
    .out_short_release_mask (out_short_release_mask),
    .out_long_release_mask  (out_long_release_mask)
  );

  always #2 clk = ~clk;

  // one scan tick through every key lane; updates the predictor state
  function automatic tick_events_t classify_tick(logic [KEY_BITS-1:0] levels);
    tick_events_t ev;
    logic         moved;
    ev = '0;
    for (int k = 0; k < KEY_BITS; k++) begin
      if (!key_enabled[k]) begin
        key_phase[k]  = KEY_IDLE;
        hold_ticks[k] = '0;
      end else begin
        case (key_phase[k])
          KEY_IDLE: begin
            if (levels[k]) begin
              key_phase[k]  = KEY_DEBOUNCE;
              hold_ticks[k] = '0;
            end
          end
          KEY_DEBOUNCE: begin
            if (hold_ticks[k] != COUNT_MAX) hold_ticks[k] = hold_ticks[k] + 1'b1;
            if (hold_ticks[k] >= COUNT_BITS'(db_limit)) begin
              if (levels[k]) begin
                ev.press[k]  = 1'b1;
                key_phase[k] = KEY_HELD;
              end else begin
                key_phase[k] = KEY_IDLE;
              end
            end
          end
          KEY_HELD: begin
            // saturated counter never repeats the long press
            moved = (hold_ticks[k] != COUNT_MAX);
            if (moved) hold_ticks[k] = hold_ticks[k] + 1'b1;
            if (moved && hold_ticks[k] == COUNT_BITS'(lp_limit)) ev.long_press[k] = 1'b1;
            if (!levels[k]) key_phase[k] = KEY_RELEASED;
          end
          default: begin
            if (hold_ticks[k] >= COUNT_BITS'(lp_limit)) ev.long_release[k] = 1'b1;
            else ev.short_release[k] = 1'b1;
            key_phase[k] = KEY_IDLE;
          end
        endcase
      end
    end
    return ev;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_mask(string name, logic [KEY_BITS-1:0] got,
                              logic [KEY_BITS-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // driver: offers queued ticks, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_events.push_back(classify_tick(in_key_levels));
      if (!in_valid || !in_stall) begin
        if (pending_levels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_key_levels <= pending_levels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks accepted results and drives the receiver stall
  always @(posedge clk) begin
    tick_events_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("result with no tick waiting");
        end else begin
          want = expected_events.pop_front();
          compare_mask("press_mask", out_press_mask, want.press);
          compare_mask("long_press_mask", out_long_press_mask, want.long_press);
          compare_mask("short_release_mask", out_short_release_mask, want.short_release);
          compare_mask("long_release_mask", out_long_release_mask, want.long_release);
        end
      end
      // long hold-off so the block backs up into its input
      if (hold_off_left != 0) begin
        out_stall     <= 1'b1;
        hold_off_left <= hold_off_left - 1;
      end else if (hold_off_seen != hold_off_requests) begin
        hold_off_seen <= hold_off_requests;
        hold_off_left <= HOLD_OFF_CYCLES - 1;
        out_stall     <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DEBOUNCE:   db_limit    = val[DB_W-1:0];
      CFG_LONG_PRESS: lp_limit    = val[LP_W-1:0];
      CFG_KEY_ENABLE: key_enabled = val[KEY_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_classifier(logic [DB_W-1:0] db, logic [LP_W-1:0] lp,
                                    logic [KEY_BITS-1:0] mask);
    write_reg(CFG_DEBOUNCE, CFG_W'(db));
    write_reg(CFG_LONG_PRESS, CFG_W'(lp));
    write_reg(CFG_KEY_ENABLE, CFG_W'(mask));
  endtask

  task automatic set_pacing(pacing_e pace);
    case (pace)
      PACE_SLOW_SINK: begin
        send_idle_pct  = 25;
        recv_stall_pct = 77;
      end
      PACE_SLOW_SOURCE: begin
        send_idle_pct  = 77;
        recv_stall_pct = 25;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // sampled off the falling edge so the driver's updates are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_levels.size() != 0 || in_valid || expected_events.size() != 0);
  endtask

  // run length for one key: short bounces, presses near the debounce limit
  // and holds around the long press point
  function automatic int pick_run(bit down);
    int db_i;
    int lp_i;
    int sel;
    int span;
    db_i = int'(db_limit);
    lp_i = int'(lp_limit);
    if (!down) return $urandom_range(1, 4);
    sel = $urandom_range(0, 9);
    if (sel < 2) return $urandom_range(1, db_i + 1);
    if (sel < 6) return db_i + $urandom_range(1, 4);
    span = lp_i + $urandom_range(0, 4) - 1;
    if (span > 400) span = $urandom_range(db_i + 2, 400);
    if (span < 1) span = 1;
    return span;
  endfunction

  task automatic queue_random_ticks(int n);
    logic [KEY_BITS-1:0] lv;
    for (int t = 0; t < n; t++) begin
      for (int k = 0; k < KEY_BITS; k++) begin
        if (run_left[k] == 0) begin
          gen_down[k] = !gen_down[k];
          run_left[k] = pick_run(gen_down[k]);
        end
        run_left[k]--;
        lv[k] = gen_down[k];
      end
      // contact noise on some ticks breaks up the sequences
      if ($urandom_range(0, 9) == 0) lv ^= KEY_BITS'($urandom_range(0, 255));
      pending_levels.push_back(lv);
    end
  endtask

  task automatic run_random_phase(logic [DB_W-1:0] db, logic [LP_W-1:0] lp,
                                  logic [KEY_BITS-1:0] mask, pacing_e pace,
                                  int n, bit squeeze);
    program_classifier(db, lp, mask);
    set_pacing(pace);
    if (squeeze) hold_off_requests++;
    queue_random_ticks(n);
    wait_drained();
  endtask

  initial begin
    // predictor reset state
    db_limit    = DEBOUNCE_RST;
    lp_limit    = LONG_PRESS_RST;
    key_enabled = KEY_ENABLE_RST;
    for (int k = 0; k < KEY_BITS; k++) begin
      key_phase[k]  = KEY_IDLE;
      hold_ticks[k] = '0;
      run_left[k]   = 0;
      gen_down[k]   = 1'b1;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // long press, long release, short release and debounce failures
    program_classifier(8'd1, 16'd3, 8'hFF);
    set_pacing(PACE_SLOW_SINK);
    pending_levels = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                       8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h00};
    wait_drained();

    // keys disabled while held fall back to idle
    set_pacing(PACE_SLOW_SOURCE);
    pending_levels = '{8'hFF, 8'hFF, 8'hFF};
    wait_drained();
    write_reg(CFG_KEY_ENABLE, CFG_W'(8'h3C));
    pending_levels = '{8'hFF, 8'h00, 8'h00};
    wait_drained();

    // zero debounce judges on the first debounce tick
    set_pacing(PACE_FREE);
    write_reg(CFG_DEBOUNCE, CFG_W'(8'd0));
    write_reg(CFG_KEY_ENABLE, CFG_W'(8'hFF));
    pending_levels = '{8'h01, 8'h01, 8'h00, 8'h00};
    wait_drained();

    // random press sequences over several register settings
    run_random_phase(8'd1, 16'd1, 8'hFF, PACE_SLOW_SINK, 150, 1'b0);
    run_random_phase(8'd255, 16'd260, 8'hFF, PACE_SLOW_SOURCE, 300, 1'b0);
    run_random_phase(8'd3, 16'd10, 8'hA5, PACE_FREE, 150, 1'b1);
    run_random_phase(DEBOUNCE_RST, LONG_PRESS_RST, KEY_ENABLE_RST, PACE_SLOW_SINK,
                     250, 1'b0);
    run_random_phase(8'd0, 16'd0, 8'hFF, PACE_SLOW_SOURCE, 150, 1'b0);
    run_random_phase(DB_W'($urandom_range(0, 12)), LP_W'($urandom_range(1, 40)),
                     KEY_BITS'($urandom_range(0, 255)), PACE_FREE, 150, 1'b1);
    run_random_phase(8'd1, 16'd4, 8'h7E, PACE_SLOW_SINK, 150, 1'b0);
    run_random_phase(8'd6, 16'hFFFF, 8'hFF, PACE_SLOW_SOURCE, 100, 1'b0);
    run_random_phase(8'd2, 16'd20, 8'h00, PACE_FREE, 50, 1'b0);

    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
